[rtl/mut_pkg.sv]
// shared constants, types and helpers of the msrp uri tokenizer
package mut_pkg;

   localparam int MAX_BUFFER_LEN = 65536;
   localparam int POS_W          = $clog2(MAX_BUFFER_LEN);

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 3;
   localparam int FIELD_W = 16;
   localparam int ACC_W   = FIELD_W + 4;

   localparam logic [CHAR_W-1:0] SEP_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] SEP_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] SEP_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] SEP_AT    = 8'h40;
   localparam logic [CHAR_W-1:0] SEP_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] DIGIT_0   = 8'h30;
   localparam logic [CHAR_W-1:0] DIGIT_9   = 8'h39;

   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE      = 3'd0,
      KIND_SCHEME    = 3'd1,
      KIND_USERINFO  = 3'd2,
      KIND_HOST      = 3'd3,
      KIND_PORT      = 3'd4,
      KIND_SESSION   = 3'd5,
      KIND_TRANSPORT = 3'd6
   } kind_type;

   function automatic logic is_separator(input logic [CHAR_W-1:0] c);
      return c inside {SEP_SPACE, SEP_COLON, SEP_SLASH, SEP_AT, SEP_SEMI};
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c inside {[DIGIT_0:DIGIT_9]};
   endfunction

endpackage

[rtl/mut_if.sv]
// request and response channel interfaces of the msrp uri tokenizer
interface mut_req_if;
   logic                       valid;
   logic                       ready;
   logic [mut_pkg::CHAR_W-1:0] char_byte;
   logic                       last_byte;

   modport source (output valid, output char_byte, output last_byte, input ready);
   modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface mut_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mut_pkg::KIND_W-1:0]  field_kind;
   logic [mut_pkg::FIELD_W-1:0] token_start;
   logic [mut_pkg::FIELD_W-1:0] token_length;
   logic [mut_pkg::FIELD_W-1:0] port_value;
   logic                        uri_done;
   logic                        list_done;
   logic                        parse_error;

   modport source (output valid, output field_kind, output token_start,
                   output token_length, output port_value, output uri_done,
                   output list_done, output parse_error, input ready);
   modport sink   (input valid, input field_kind, input token_start,
                   input token_length, input port_value, input uri_done,
                   input list_done, input parse_error, output ready);
endinterface

[rtl/msrp_uri_tokenizer_top.sv]
// msrp uri list tokenizer: one byte per request, one token report when a token ends
//
// One byte is taken every clock cycle while the response side keeps up. Each byte
// passes an input register and then a single state update that writes the response
// register, where the report for the byte that ends a token is held. The rate is
// set by the per-byte parser state update, which must see the previous byte's result
// before the next. A response is given only when a token ends or on the byte flagged
// as last; bytes inside a token or separator runs give none. After the last byte all
// parser state returns to its reset values, ready for the next buffer.
// Offsets wrap modulo MAX_BUFFER_LEN; lengths and port values saturate at 65535.
module msrp_uri_tokenizer_top (
   input logic      clock,
   input logic      reset,
   mut_req_if.sink  req_bus,
   mut_rsp_if.source rsp_bus
);
   import mut_pkg::*;

   typedef enum logic [2:0] {
      ST_SCHEME    = 3'd0,
      ST_USER_HOST = 3'd1,
      ST_HOST      = 3'd2,
      ST_PORT      = 3'd3,
      ST_SESSION   = 3'd4,
      ST_TRANSPORT = 3'd5
   } stage_type;

   localparam int LEN_W = POS_W + 1;

   // input register
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   // parser state
   stage_type          stage_ff, stage_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic               inside_ff, inside_in;
   logic [FIELD_W-1:0] acc_ff, acc_in;
   logic               open_ff, open_in;

   // response register
   logic               rsp_valid_ff;
   kind_type           kind_ff, kind_in;
   logic [FIELD_W-1:0] tstart_ff, tstart_in;
   logic [FIELD_W-1:0] tlen_ff, tlen_in;
   logic [FIELD_W-1:0] pval_ff, pval_in;
   logic               udone_ff, udone_in;
   logic               ldone_ff, ldone_in;
   logic               err_ff, err_in;
   logic               emit_in;

   logic out_free, proc_fire, req_fire;
   logic sep, tok_end;
   logic [FIELD_W-1:0] acc_base;
   logic               open_base;
   logic [ACC_W-1:0]   acc_wide;
   logic [LEN_W-1:0]   diff;
   logic [FIELD_W:0]   len_full;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign proc_fire = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_fire  = req_bus.valid && req_bus.ready;

   always_comb begin
      sep       = is_separator(in_char_ff);
      start_in  = start_ff;
      inside_in = inside_ff;
      stage_in  = stage_ff;
      acc_base  = inside_ff ? acc_ff : '0;
      open_base = inside_ff ? open_ff : 1'b1;
      acc_in    = acc_ff;
      open_in   = open_ff;
      acc_wide  = '0;
      kind_in   = KIND_NONE;
      tstart_in = '0;
      tlen_in   = '0;
      pval_in   = '0;
      udone_in  = 1'b0;
      ldone_in  = 1'b0;
      err_in    = 1'b0;
      emit_in   = 1'b0;

      if (!sep) begin
         if (!inside_ff) begin
            inside_in = 1'b1;
            start_in  = pos_ff;
         end
         acc_in  = acc_base;
         open_in = open_base;
         if (open_base) begin
            if (is_digit(in_char_ff)) begin
               acc_wide = ({acc_base, 3'b000} + {2'b00, acc_base, 1'b0})
                        + ACC_W'(in_char_ff - DIGIT_0);
               acc_in   = (acc_wide > ACC_W'(FIELD_MAX)) ? FIELD_MAX
                                                         : acc_wide[FIELD_W-1:0];
            end else begin
               open_in = 1'b0;
            end
         end
      end

      // token started earlier or on this very byte
      tok_end = inside_in && (sep || in_last_ff);
      if (pos_ff >= start_in) diff = LEN_W'(pos_ff) - LEN_W'(start_in);
      else diff = LEN_W'(pos_ff) + LEN_W'(MAX_BUFFER_LEN) - LEN_W'(start_in);
      len_full = (FIELD_W + 1)'(diff) + (FIELD_W + 1)'(!sep);

      if (tok_end) begin
         tlen_in   = (len_full > (FIELD_W + 1)'(FIELD_MAX)) ? FIELD_MAX
                                                           : len_full[FIELD_W-1:0];
         tstart_in = FIELD_W'(start_in);
         case (stage_ff)
            ST_SCHEME: begin
               kind_in  = KIND_SCHEME;
               stage_in = ST_USER_HOST;
            end
            ST_USER_HOST, ST_HOST: begin
               kind_in = KIND_HOST;
               if (sep && in_char_ff == SEP_AT && stage_ff == ST_USER_HOST) begin
                  kind_in  = KIND_USERINFO;
                  stage_in = ST_HOST;
               end else if (sep && in_char_ff == SEP_COLON) stage_in = ST_PORT;
               else if (sep && in_char_ff == SEP_SLASH) stage_in = ST_SESSION;
               else if (sep && in_char_ff == SEP_SEMI) stage_in = ST_TRANSPORT;
               else stage_in = ST_SCHEME;
            end
            ST_PORT: begin
               kind_in = KIND_PORT;
               pval_in = acc_in;
               if (sep && in_char_ff == SEP_SLASH) stage_in = ST_SESSION;
               else if (sep && in_char_ff == SEP_SEMI) stage_in = ST_TRANSPORT;
               else stage_in = ST_SCHEME;
            end
            ST_SESSION: begin
               kind_in = KIND_SESSION;
               if (sep && in_char_ff == SEP_SEMI) stage_in = ST_TRANSPORT;
               else stage_in = ST_SCHEME;
            end
            default: begin
               kind_in  = KIND_TRANSPORT;
               stage_in = ST_SCHEME;
            end
         endcase
         udone_in  = (stage_in == ST_SCHEME);
         inside_in = 1'b0;
         emit_in   = 1'b1;
      end

      if (in_last_ff) begin
         emit_in   = 1'b1;
         ldone_in  = 1'b1;
         err_in    = (stage_in != ST_SCHEME);
         stage_in  = ST_SCHEME;
         pos_in    = '0;
         start_in  = '0;
         inside_in = 1'b0;
         acc_in    = '0;
         open_in   = 1'b1;
      end else begin
         pos_in = (pos_ff == POS_W'(MAX_BUFFER_LEN - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stage_ff     <= ST_SCHEME;
         pos_ff       <= '0;
         start_ff     <= '0;
         inside_ff    <= 1'b0;
         acc_ff       <= '0;
         open_ff      <= 1'b1;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
            in_char_ff  <= req_bus.char_byte;
            in_last_ff  <= req_bus.last_byte;
         end else if (proc_fire) begin
            in_valid_ff <= 1'b0;
         end

         if (proc_fire) begin
            rsp_valid_ff <= emit_in;
            stage_ff     <= stage_in;
            pos_ff       <= pos_in;
            start_ff     <= start_in;
            inside_ff    <= inside_in;
            acc_ff       <= acc_in;
            open_ff      <= open_in;
            kind_ff      <= kind_in;
            tstart_ff    <= tstart_in;
            tlen_ff      <= tlen_in;
            pval_ff      <= pval_in;
            udone_ff     <= udone_in;
            ldone_ff     <= ldone_in;
            err_ff       <= err_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.field_kind   = kind_ff;
   assign rsp_bus.token_start  = tstart_ff;
   assign rsp_bus.token_length = tlen_ff;
   assign rsp_bus.port_value   = pval_ff;
   assign rsp_bus.uri_done     = udone_ff;
   assign rsp_bus.list_done    = ldone_ff;
   assign rsp_bus.parse_error  = err_ff;

`ifndef SYNTH
   // state is back at reset values once the last byte has gone through
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_last_ff |=> pos_ff == '0 && !inside_ff && stage_ff == ST_SCHEME)
      else $error("parser state not cleared after last byte");

   // an empty report only ever closes the buffer
   a_none_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_NONE |-> ldone_ff)
      else $error("empty report without list_done");

   a_error_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff |-> ldone_ff && !udone_ff)
      else $error("parse_error outside the end of buffer");

   a_port_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_PORT |-> pval_ff == '0)
      else $error("port value on a non-port token");

   // a held request in the input stage keeps its byte while responses stall
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_char_ff)
                                   && $stable(in_last_ff))
      else $error("input stage lost a stalled byte");
`endif

endmodule
